// ===== rtl/dcmste_pkg.sv =====
// ----------------------------------------------------------------------------
// dcmste_pkg: shared types and helpers for the DC motor speed/torque estimator
// Fixed-point format, register map codes, clamp and divider step functions.
// ----------------------------------------------------------------------------
`default_nettype none

package dcmste_pkg;

  localparam int unsigned FRAC_BITS = 16;
  // Dividend width of the speed quotients: 32-bit magnitude scaled by FRAC_BITS.
  localparam int unsigned DIV_W     = 32 + FRAC_BITS;

  localparam logic [2:0] REG_MODEL_READY  = 3'd0;
  localparam logic [2:0] REG_SPEED_COEFF  = 3'd1;
  localparam logic [2:0] REG_TORQUE_COEFF = 3'd2;
  localparam logic [2:0] REG_ARM_RES      = 3'd3;
  localparam logic [2:0] REG_WIRE_RES     = 3'd4;
  localparam logic [2:0] REG_MAX_VOLTAGE  = 3'd5;
  localparam logic [2:0] REG_NOM_FIELD    = 3'd6;
  localparam logic [2:0] REG_IR_COMP      = 3'd7;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } clamp_t;

  // Values that ride along the divider pipeline.
  typedef struct packed {
    logic signed [31:0] torque;
    logic signed [31:0] emf;
    logic signed [31:0] wire_drop;
    logic               sat_base;  // always counts
    logic               sat_spd;   // counts only with a live field
    logic               fld_zero;
  } side_t;

  typedef struct packed {
    logic [31:0]      rem;
    logic [DIV_W-1:0] rq;
  } divst_t;

  function automatic clamp_t sat32(input logic signed [64:0] v);
    clamp_t r;
    r.sat = 1'b0;
    if (v > 65'sd2147483647) begin
      r.val = 32'sh7fff_ffff;
      r.sat = 1'b1;
    end else if (v < -65'sd2147483648) begin
      r.val = 32'sh8000_0000;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Fixed-point product: floor shift, then clamp.
  function automatic clamp_t mul_fx(input logic signed [63:0] p);
    logic signed [63:0] sh;
    sh = p >>> FRAC_BITS;
    return sat32({sh[63], sh});
  endfunction

  // One restoring division step: one quotient bit.
  function automatic divst_t div_step(input divst_t s, input logic [31:0] dm);
    divst_t      r;
    logic [32:0] tr;
    logic [32:0] df;
    tr = {s.rem, s.rq[DIV_W-1]};
    df = tr - {1'b0, dm};
    if (!df[32]) begin
      r.rem = df[31:0];
      r.rq  = {s.rq[DIV_W-2:0], 1'b1};
    end else begin
      r.rem = tr[31:0];
      r.rq  = {s.rq[DIV_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Signed, saturated quotient from magnitude and sign information.
  function automatic clamp_t div_fin(input logic [DIV_W-1:0] q, input logic neg,
                                     input logic zero, input logic nonneg);
    clamp_t r;
    r.sat = 1'b0;
    if (zero) begin
      r.val = nonneg ? 32'sh7fff_ffff : 32'sh8000_0000;
      r.sat = 1'b1;
    end else if (neg) begin
      if (q > {{FRAC_BITS{1'b0}}, 32'h8000_0000}) begin
        r.val = 32'sh8000_0000;
        r.sat = 1'b1;
      end else begin
        r.val = ~q[31:0] + 32'd1;
      end
    end else if (q > {{FRAC_BITS{1'b0}}, 32'h7fff_ffff}) begin
      r.val = 32'sh7fff_ffff;
      r.sat = 1'b1;
    end else begin
      r.val = q[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dcmste_div.sv =====
// ----------------------------------------------------------------------------
// dcmste_div: twin pipelined restoring divider
// Two quotients (a << FRAC_BITS) / d with a shared divisor, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmste_div
  import dcmste_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic signed [31:0] num0_i,
  input  wire logic signed [31:0] num1_i,
  input  wire logic signed [31:0] den_i,
  input  wire side_t              side_i,
  output logic                    valid_o,
  output clamp_t                  quot0_o,
  output clamp_t                  quot1_o,
  output side_t                   side_o
);

  logic             v_q    [DIV_W+1];
  divst_t           s0_q   [DIV_W+1];
  divst_t           s1_q   [DIV_W+1];
  logic [31:0]      dm_q   [DIV_W+1];
  logic             neg0_q [DIV_W+1];
  logic             neg1_q [DIV_W+1];
  logic             pos0_q [DIV_W+1];
  logic             pos1_q [DIV_W+1];
  logic             zero_q [DIV_W+1];
  side_t            side_q [DIV_W+1];

  // Entry: take magnitudes and signs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q[0]   <= '{rem: 32'd0, rq: {mag32(num0_i), {FRAC_BITS{1'b0}}}};
      s1_q[0]   <= '{rem: 32'd0, rq: {mag32(num1_i), {FRAC_BITS{1'b0}}}};
      dm_q[0]   <= mag32(den_i);
      neg0_q[0] <= num0_i[31] ^ den_i[31];
      neg1_q[0] <= num1_i[31] ^ den_i[31];
      pos0_q[0] <= !num0_i[31];
      pos1_q[0] <= !num1_i[31];
      zero_q[0] <= (den_i == 32'sd0);
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= DIV_W; k++) begin : g_stg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s0_q[k]   <= div_step(s0_q[k-1], dm_q[k-1]);
        s1_q[k]   <= div_step(s1_q[k-1], dm_q[k-1]);
        dm_q[k]   <= dm_q[k-1];
        neg0_q[k] <= neg0_q[k-1];
        neg1_q[k] <= neg1_q[k-1];
        pos0_q[k] <= pos0_q[k-1];
        pos1_q[k] <= pos1_q[k-1];
        zero_q[k] <= zero_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[DIV_W];
  assign side_o  = side_q[DIV_W];
  assign quot0_o = div_fin(s0_q[DIV_W].rq, neg0_q[DIV_W], zero_q[DIV_W], pos0_q[DIV_W]);
  assign quot1_o = div_fin(s1_q[DIV_W].rq, neg1_q[DIV_W], zero_q[DIV_W], pos1_q[DIV_W]);

endmodule

`default_nettype wire

// ===== rtl/dc_motor_speed_torque_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// dc_motor_speed_torque_estimator_unit: back-EMF speed and torque estimator
// Wire drop, compensated EMF, speed, reachable speed and torque per sample.
// ----------------------------------------------------------------------------
// Registers from beat to result: stage 1, stage 2, stage 3, the divider entry and steps, the output register.
// Throughput: one sample beat per cycle while no result waits; the two speed quotients run through a
// restoring divider that retires one quotient bit per stage.
// The whole pipeline advances together and holds while the result waits.
// Reset clears the configuration registers and every stage valid bit; data
// registers are left as they are, and there is no clearing pass.
`default_nettype none

module dc_motor_speed_torque_estimator_unit
  import dcmste_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // sample channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic signed [31:0] armature_current_i,
  input  wire logic signed [31:0] armature_emf_i,
  input  wire logic signed [31:0] field_current_i,
  input  wire logic        excitation_external_i,
  input  wire logic        field_current_zero_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [31:0] speed_o,
  output logic signed [31:0] speed_limit_o,
  output logic signed [31:0] torque_o,
  output logic signed [31:0] emf_out_o,
  output logic signed [31:0] wire_drop_o,
  output logic             saturated_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        model_ready_q;
  logic [30:0] speed_coeff_q, torque_coeff_q, arm_res_q, wire_res_q;
  logic [30:0] max_voltage_q, nom_field_q;
  logic        ir_comp_q;
  logic [2:0]  reg_idx;
  logic        reg_wr;

  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_ready_q  <= 1'b0;
      speed_coeff_q  <= '0;
      torque_coeff_q <= '0;
      arm_res_q      <= '0;
      wire_res_q     <= '0;
      max_voltage_q  <= '0;
      nom_field_q    <= '0;
      ir_comp_q      <= 1'b0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_MODEL_READY:  model_ready_q  <= pwdata[0];
        REG_SPEED_COEFF:  speed_coeff_q  <= pwdata[30:0];
        REG_TORQUE_COEFF: torque_coeff_q <= pwdata[30:0];
        REG_ARM_RES:      arm_res_q      <= pwdata[30:0];
        REG_WIRE_RES:     wire_res_q     <= pwdata[30:0];
        REG_MAX_VOLTAGE:  max_voltage_q  <= pwdata[30:0];
        REG_NOM_FIELD:    nom_field_q    <= pwdata[30:0];
        REG_IR_COMP:      ir_comp_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODEL_READY:  prdata = {31'd0, model_ready_q};
      REG_SPEED_COEFF:  prdata = {1'b0, speed_coeff_q};
      REG_TORQUE_COEFF: prdata = {1'b0, torque_coeff_q};
      REG_ARM_RES:      prdata = {1'b0, arm_res_q};
      REG_WIRE_RES:     prdata = {1'b0, wire_res_q};
      REG_MAX_VOLTAGE:  prdata = {1'b0, max_voltage_q};
      REG_NOM_FIELD:    prdata = {1'b0, nom_field_q};
      REG_IR_COMP:      prdata = {31'd0, ir_comp_q};
      default:          prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline enable: every stage advances unless a finished result is stuck
  // in the output register. A beat taken while the model is not ready is
  // dropped at entry and never produces a result.
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // --------------------------------------------------------------------------
  // Stage 1: the four 32x32 products (I*Rw, I*Ra, I*Iexc, Cn*Iexc)
  // --------------------------------------------------------------------------
  logic signed [31:0] iexc;
  logic signed [31:0] cn_s, rw_s, ra_s;
  logic               v1_q;
  logic signed [63:0] pw1_q, pr1_q, pip1_q, pcn1_q;
  logic signed [31:0] emf1_q;
  logic               fz1_q;

  assign iexc = excitation_external_i ? $signed({1'b0, nom_field_q}) : field_current_i;
  assign cn_s = $signed({1'b0, speed_coeff_q});
  assign rw_s = $signed({1'b0, wire_res_q});
  assign ra_s = $signed({1'b0, arm_res_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i && model_ready_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw1_q  <= armature_current_i * rw_s;
      pr1_q  <= armature_current_i * ra_s;
      pip1_q <= armature_current_i * iexc;
      pcn1_q <= cn_s * iexc;
      emf1_q <= armature_emf_i;
      // Zero field only counts when the field comes from the measurement.
      fz1_q  <= field_current_zero_i && !excitation_external_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale and clamp the products, form the compensated EMF and the
  // EMF headroom Umax - I*Ra (less the wire drop when compensating).
  // --------------------------------------------------------------------------
  clamp_t uw_c, ur_c, ip_c, cn_c, em_a, em_b, er_b;
  logic signed [64:0] em_sum, em_sub, er_sub;
  logic signed [31:0] erot2_d, emax2_d;
  logic               satb2_d;

  always_comb begin
    uw_c   = mul_fx(pw1_q);
    ur_c   = mul_fx(pr1_q);
    ip_c   = mul_fx(pip1_q);
    cn_c   = mul_fx(pcn1_q);
    em_sum = $signed({34'd0, max_voltage_q}) - 65'(ur_c.val);
    em_a   = sat32(em_sum);
    em_sub = 65'(em_a.val) - 65'(uw_c.val);
    er_sub = 65'(emf1_q) - 65'(uw_c.val);
    em_b   = sat32(em_sub);
    er_b   = sat32(er_sub);
    satb2_d = uw_c.sat || ur_c.sat || em_a.sat;
    if (ir_comp_q) begin
      erot2_d = er_b.val;
      emax2_d = em_b.val;
      satb2_d = satb2_d || em_b.sat || er_b.sat;
    end else begin
      erot2_d = emf1_q;
      emax2_d = em_a.val;
    end
  end

  logic               v2_q;
  logic signed [31:0] uw2_q, erot2_q, emax2_q, ip2_q, cn2_q;
  logic               satb2_q, sats2_q, fz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      uw2_q   <= uw_c.val;
      erot2_q <= erot2_d;
      emax2_q <= emax2_d;
      ip2_q   <= ip_c.val;
      cn2_q   <= cn_c.val;
      satb2_q <= satb2_d;
      sats2_q <= ip_c.sat || cn_c.sat;
      fz2_q   <= fz1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: torque product Cm * (I*Iexc)
  // --------------------------------------------------------------------------
  logic               v3_q;
  logic signed [63:0] pm3_q;
  logic signed [31:0] uw3_q, erot3_q, emax3_q, cn3_q;
  logic               satb3_q, sats3_q, fz3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm3_q   <= $signed({1'b0, torque_coeff_q}) * ip2_q;
      uw3_q   <= uw2_q;
      erot3_q <= erot2_q;
      emax3_q <= emax2_q;
      cn3_q   <= cn2_q;
      satb3_q <= satb2_q;
      sats3_q <= sats2_q;
      fz3_q   <= fz2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: E / (Cn*Iexc) and Emax / (Cn*Iexc); torque rides along.
  // --------------------------------------------------------------------------
  clamp_t trq_c;
  side_t  side_in, side_out;
  logic   vd;
  clamp_t q0, q1;

  always_comb begin
    trq_c             = mul_fx(pm3_q);
    side_in.torque    = trq_c.val;
    side_in.emf       = erot3_q;
    side_in.wire_drop = uw3_q;
    side_in.sat_base  = satb3_q;
    side_in.sat_spd   = sats3_q || trq_c.sat;
    side_in.fld_zero  = fz3_q;
  end

  dcmste_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num0_i  (erot3_q),
    .num1_i  (emax3_q),
    .den_i   (cn3_q),
    .side_i  (side_in),
    .valid_o (vd),
    .quot0_o (q0),
    .quot1_o (q1),
    .side_o  (side_out)
  );

  // --------------------------------------------------------------------------
  // Output register: zero speed and torque on a dead field, merge flags.
  // --------------------------------------------------------------------------
  logic signed [31:0] speed_q, speed_lim_q, torque_q, emf_q, wdrop_q;
  logic               sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      emf_q   <= side_out.emf;
      wdrop_q <= side_out.wire_drop;
      if (side_out.fld_zero) begin
        speed_q     <= 32'sd0;
        speed_lim_q <= 32'sd0;
        torque_q    <= 32'sd0;
        sat_q       <= side_out.sat_base;
      end else begin
        speed_q     <= q0.val;
        speed_lim_q <= q1.val;
        torque_q    <= side_out.torque;
        sat_q       <= side_out.sat_base || side_out.sat_spd || q0.sat || q1.sat;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign speed_o       = speed_q;
  assign speed_limit_o = speed_lim_q;
  assign torque_o      = torque_q;
  assign emf_out_o     = emf_q;
  assign wire_drop_o   = wdrop_q;
  assign saturated_o   = sat_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the DC motor speed/torque estimator unit
// Drives sample beats under several register settings and idle patterns,
// predicts each result in fixed point and checks it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import dcmste_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  // Beat-to-result latency plus margin; used before register writes and at the end.
  localparam int unsigned SETTLE_CYCLES = 3 + DIV_W + 2 + 10;

  typedef struct packed {
    logic signed [31:0] cur;
    logic signed [31:0] emf;
    logic signed [31:0] fld;
    logic               ext;
    logic               fz;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] speed;
    logic signed [31:0] speed_limit;
    logic signed [31:0] torque;
    logic signed [31:0] emf_out;
    logic signed [31:0] wire_drop;
    logic               sat;
  } estimate_t;

  // One directed row: sample, plus a hand-written result where has_typed is set.
  typedef struct packed {
    sample_t   smp;
    logic      has_typed;
    estimate_t typed;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  sample_t     drv;
  logic        out_valid_o;
  logic        out_ready_i;
  logic signed [31:0] speed_o, speed_limit_o, torque_o, emf_out_o, wire_drop_o;
  logic        saturated_o;

  // Register mirror
  logic   cfg_ready, cfg_ir;
  longint cfg_cn, cfg_cm, cfg_ra, cfg_rw, cfg_umax, cfg_nom;

  bit          clip_hit;
  estimate_t   pending_estimates[$];
  int unsigned err_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  dc_motor_speed_torque_estimator_unit u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .armature_current_i    (drv.cur),
    .armature_emf_i        (drv.emf),
    .field_current_i       (drv.fld),
    .excitation_external_i (drv.ext),
    .field_current_zero_i  (drv.fz),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .speed_o               (speed_o),
    .speed_limit_o         (speed_limit_o),
    .torque_o              (torque_o),
    .emf_out_o             (emf_out_o),
    .wire_drop_o           (wire_drop_o),
    .saturated_o           (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------
  // Clamp to the signed 32-bit range and remember that it happened.
  function automatic longint clip32(longint v);
    if (v > S32_MAX) begin
      clip_hit = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      clip_hit = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  // Product with the fraction dropped toward minus infinity.
  function automatic longint fx_product(longint a, longint b);
    longint p;
    p = a * b;
    return clip32(p >>> FRAC_BITS);
  endfunction

  // Scaled quotient rounded toward zero; a zero divisor pins to the rail of the sign.
  function automatic longint fx_quotient(longint a, longint b);
    if (b == 0) begin
      clip_hit = 1'b1;
      return (a >= 0) ? S32_MAX : S32_MIN;
    end
    return clip32((a * (64'sd1 <<< FRAC_BITS)) / b);
  endfunction

  function automatic estimate_t estimate(sample_t s);
    longint    i_arm, e_arm, drop_w, drop_r, e_lim, i_exc, flux, n, n_lim, m;
    bit        no_field;
    estimate_t r;
    clip_hit = 1'b0;
    n        = 0;
    n_lim    = 0;
    m        = 0;
    no_field = 1'b0;
    i_arm    = longint'(s.cur);
    e_arm    = longint'(s.emf);
    drop_w   = fx_product(i_arm, cfg_rw);
    drop_r   = fx_product(i_arm, cfg_ra);
    e_lim    = clip32(cfg_umax - drop_r);
    if (cfg_ir) begin
      e_arm = clip32(e_arm - drop_w);
      e_lim = clip32(e_lim - drop_w);
    end
    // External field always uses the nominal current and ignores the zero flag.
    if (s.ext) begin
      i_exc = cfg_nom;
    end else begin
      no_field = s.fz;
      i_exc    = longint'(s.fld);
    end
    if (!no_field) begin
      flux  = fx_product(cfg_cn, i_exc);
      n     = fx_quotient(e_arm, flux);
      n_lim = fx_quotient(e_lim, flux);
      m     = fx_product(cfg_cm, fx_product(i_arm, i_exc));
    end
    r.speed       = n[31:0];
    r.speed_limit = n_lim[31:0];
    r.torque      = m[31:0];
    r.emf_out     = e_arm[31:0];
    r.wire_drop   = drop_w[31:0];
    r.sat         = clip_hit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    // The access phase completed at the edge just passed; update the mirror.
    case (idx)
      REG_MODEL_READY:  cfg_ready = data[0];
      REG_SPEED_COEFF:  cfg_cn    = longint'({1'b0, data[30:0]});
      REG_TORQUE_COEFF: cfg_cm    = longint'({1'b0, data[30:0]});
      REG_ARM_RES:      cfg_ra    = longint'({1'b0, data[30:0]});
      REG_WIRE_RES:     cfg_rw    = longint'({1'b0, data[30:0]});
      REG_MAX_VOLTAGE:  cfg_umax  = longint'({1'b0, data[30:0]});
      REG_NOM_FIELD:    cfg_nom   = longint'({1'b0, data[30:0]});
      REG_IR_COMP:      cfg_ir    = data[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic ready, logic [31:0] cn, logic [31:0] cm,
                               logic [31:0] ra, logic [31:0] rw, logic [31:0] umax,
                               logic [31:0] nom, logic ir);
    reg_write(REG_MODEL_READY,  {31'd0, ready});
    reg_write(REG_SPEED_COEFF,  cn);
    reg_write(REG_TORQUE_COEFF, cm);
    reg_write(REG_ARM_RES,      ra);
    reg_write(REG_WIRE_RES,     rw);
    reg_write(REG_MAX_VOLTAGE,  umax);
    reg_write(REG_NOM_FIELD,    nom);
    reg_write(REG_IR_COMP,      {31'd0, ir});
  endtask

  // ---------------------------------------------------------------------------
  // Sample channel
  // ---------------------------------------------------------------------------
  // Present one beat, idling at random first; valid stays high after acceptance
  // so back-to-back beats need no extra toggle.
  task automatic send_sample(sample_t s, logic use_typed, estimate_t typed);
    estimate_t want;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    drv        = s;
    in_valid_i = 1'b1;
    want       = use_typed ? typed : estimate(s);
    do @(posedge clk_i); while (!in_ready_o);
    if (cfg_ready) pending_estimates.push_back(want);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk_i);
  endtask

  // Bias toward small physical values, with rails and raw noise mixed in.
  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'd0;
      3, 4:    return $urandom;
      5:       return 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
      default: return 32'($signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_param();
    case ($urandom_range(0, 5))
      0:       return 32'hffff_ffff;
      1:       return 32'd0;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    estimate_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch("unexpected result", speed_o, 32'd0);
      end else begin
        want = pending_estimates.pop_front();
        if (speed_o !== want.speed) report_mismatch("speed", speed_o, want.speed);
        if (speed_limit_o !== want.speed_limit)
          report_mismatch("speed_limit", speed_limit_o, want.speed_limit);
        if (torque_o !== want.torque) report_mismatch("torque", torque_o, want.torque);
        if (emf_out_o !== want.emf_out) report_mismatch("emf_out", emf_out_o, want.emf_out);
        if (wire_drop_o !== want.wire_drop)
          report_mismatch("wire_drop", wire_drop_o, want.wire_drop);
        if (saturated_o !== want.sat)
          report_mismatch("saturated", {31'd0, saturated_o}, {31'd0, want.sat});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run limit
  // ---------------------------------------------------------------------------
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  localparam int unsigned N_ROWS = 16;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] PMAX = 32'h7fff_ffff;
  localparam logic [31:0] NMAX = 32'h8000_0000;

  row_t directed_rows [N_ROWS];

  initial begin
    sample_t     s;
    estimate_t   none;
    int unsigned phase, k, n_items;
    none = '0;
    // Under the directed settings: Cn = Cm = Umax = Inom = 1.0, no resistances.
    directed_rows = '{
      // zero field flag: speed, limit and torque forced to zero
      '{'{32'd0, 32'h0002_0000, ONE, 1'b0, 1'b1}, 1'b1,
        '{32'd0, 32'd0, 32'd0, 32'h0002_0000, 32'd0, 1'b0}},
      // zero divisor, positive numerators pin high
      '{'{32'd0, ONE, 32'd0, 1'b0, 1'b0}, 1'b1,
        '{PMAX, PMAX, 32'd0, ONE, 32'd0, 1'b1}},
      // zero divisor, negative EMF pins low
      '{'{32'd0, 32'hffff_ffff, 32'd0, 1'b0, 1'b0}, 1'b1,
        '{NMAX, PMAX, 32'd0, 32'hffff_ffff, 32'd0, 1'b1}},
      // unit field: speed equals EMF
      '{'{32'd0, 32'h0002_0000, ONE, 1'b0, 1'b0}, 1'b1,
        '{32'h0002_0000, ONE, 32'd0, 32'h0002_0000, 32'd0, 1'b0}},
      // external field ignores the zero flag and the measured field
      '{'{32'd0, 32'h0002_0000, 32'd0, 1'b1, 1'b1}, 1'b1,
        '{32'h0002_0000, ONE, 32'd0, 32'h0002_0000, 32'd0, 1'b0}},
      '{'{NMAX, PMAX, PMAX, 1'b0, 1'b0}, 1'b0, none},
      '{'{PMAX, NMAX, NMAX, 1'b0, 1'b0}, 1'b0, none},
      '{'{NMAX, NMAX, NMAX, 1'b0, 1'b0}, 1'b0, none},
      '{'{PMAX, PMAX, PMAX, 1'b1, 1'b0}, 1'b0, none},
      '{'{32'hffff_ffff, ONE, 32'd1, 1'b0, 1'b0}, 1'b0, none},
      '{'{32'hffff_0000, NMAX, 32'hffff_ffff, 1'b0, 1'b0}, 1'b0, none},
      '{'{32'h0003_8000, 32'h0064_0000, 32'h0000_8000, 1'b0, 1'b0}, 1'b0, none},
      '{'{32'hfffc_8000, 32'hff9c_0000, 32'hffff_8000, 1'b0, 1'b0}, 1'b0, none},
      '{'{32'h0000_0001, 32'h0000_0001, 32'h7fff_ffff, 1'b0, 1'b0}, 1'b0, none},
      '{'{NMAX, 32'd0, 32'd0, 1'b0, 1'b1}, 1'b0, none},
      '{'{PMAX, 32'h1234_5678, 32'hedcb_a988, 1'b1, 1'b1}, 1'b0, none}
    };

    // Hold every input quiet through reset.
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    drv            = '0;
    out_ready_i    = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    err_count      = 0;
    cfg_ready      = 1'b0;
    cfg_ir         = 1'b0;
    cfg_cn         = 0;
    cfg_cm         = 0;
    cfg_ra         = 0;
    cfg_rw         = 0;
    cfg_umax       = 0;
    cfg_nom        = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Model not ready out of reset: these beats produce nothing.
    for (k = 0; k < 3; k++) begin
      s = {pick_q16(), pick_q16(), pick_q16(), 2'($urandom)};
      send_sample(s, 1'b0, none);
    end
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    // Directed table
    load_settings(1'b1, ONE, ONE, 32'd0, 32'd0, ONE, ONE, 1'b0);
    for (k = 0; k < N_ROWS; k++)
      send_sample(directed_rows[k].smp, directed_rows[k].has_typed, directed_rows[k].typed);
    drain();

    // Random phases: rotate idle pattern and register setting per phase.
    for (phase = 0; phase < 11; phase++) begin
      repeat (SETTLE_CYCLES) @(negedge clk_i);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      case (phase % 5)
        // all rails: bit 31 written too, must be dropped
        1: load_settings(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                         32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, phase[0]);
        // every coefficient at zero
        2: load_settings(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, phase[0]);
        3: load_settings(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, phase[0]);
        default: load_settings(1'b1, pick_param(), pick_param(), pick_param(),
                               pick_param(), pick_param(), pick_param(), phase[0]);
      endcase
      // One phase runs with the model not ready; its beats are swallowed.
      if (phase == 6) reg_write(REG_MODEL_READY, 32'd0);
      n_items = (phase == 6) ? 20 : 75;
      for (k = 0; k < n_items; k++) begin
        s = {pick_q16(), pick_q16(), pick_q16(), 2'($urandom)};
        send_sample(s, 1'b0, none);
        // Pause the sender once until the pipeline empties.
        if (phase == 3 && k == 40) drain();
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== dc_motor_speed_torque_estimator_unit.f =====
rtl/dcmste_pkg.sv
rtl/dcmste_div.sv
rtl/dc_motor_speed_torque_estimator_unit.sv
sim/tb.sv
